>>> sv/bicycle_speed_distance_meter_defines.svh
// Assertion macros shared by the meter's RTL files.
`ifndef BICYCLE_SPEED_DISTANCE_METER_DEFINES_SVH
`define BICYCLE_SPEED_DISTANCE_METER_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define BSDM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define BSDM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/bsdm_pkg.sv
// Shared types, widths and constants of the bicycle speed and distance meter.
`default_nettype none
package bsdm_pkg;

    // Configuration register widths and reset values
    localparam int CIRC_W     = 12;
    localparam int DEB_W      = 8;
    localparam int HOLD_W     = 16;
    localparam int PER_W      = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CIRC_W-1:0] CIRC_RST   = 12'd2070;
    localparam logic [DEB_W-1:0]  DEB_RST    = 8'd10;
    localparam logic [HOLD_W-1:0] HOLD_RST   = 16'd2000;
    localparam logic [PER_W-1:0]  PERIOD_RST = 16'd1000;

    // State widths
    localparam int QUIET_W   = 9;
    localparam int HOLDCNT_W = 17;
    localparam int PERCNT_W  = 17;
    localparam int TURN_W    = 8;
    localparam int SPEED_W   = 21;
    localparam int DIST_W    = 40;
    localparam int SECS_W    = 32;
    localparam int OUT_W     = 19;
    localparam int MODE_W    = 2;

    // Arithmetic widths
    localparam int PROD_W  = TURN_W + CIRC_W;
    localparam int SUM_W   = SPEED_W + 1;
    localparam int DIVD_W  = DIST_W + 4;
    localparam int DIVS_W  = SECS_W + 5;

    // Speed in centi km/h is floor(speed * 9 / 25): multiply by 9 * ceil(2^29 / 25)
    // and keep the bits above 29, exact for every 21-bit speed
    localparam int SPD_SHIFT   = 29;
    localparam int SPD_RECIP_W = 28;
    localparam int SPD_PROD_W  = SPEED_W + SPD_RECIP_W;
    localparam logic [SPD_RECIP_W-1:0] SPD_RECIP = 28'd193273533;

    // Divider sequencing
    localparam int STEP_W    = 6;
    localparam int DIV_STEPS = DIVD_W;

    // Stream widths
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 2 * OUT_W + DIST_W + SECS_W + MODE_W;
    localparam int M_TUSER_W = 2;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_CIRC     = 2'd0,
        CFG_DEBOUNCE = 2'd1,
        CFG_HOLD     = 2'd2,
        CFG_PERIOD   = 2'd3
    } cfg_index_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_LOAD,
        ST_DIVIDE,
        ST_STORE,
        ST_OUTPUT
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic tick;
        logic update;
        logic div_load;
        logic div_step;
        logic store;
        logic out_load;
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic recompute;
        logic clear;
    } dp_status_t;

    // Clamp a quotient to the 19-bit speed outputs
    function automatic logic [OUT_W-1:0] sat_out(input logic [DIVD_W-1:0] v);
        logic [OUT_W-1:0] r;
        r = (|v[DIVD_W-1:OUT_W]) ? '1 : v[OUT_W-1:0];
        return r;
    endfunction

endpackage
`default_nettype wire

>>> sv/bicycle_speed_distance_meter.sv
// Top level of the bicycle speed and distance meter.
//
// Usage:
//   One input request per millisecond tick on s_axis: bit 0 is the raw mode
//   button level, bit 1 the raw wheel sensor level. Each tick gives exactly
//   one result request on m_axis with speed, average speed, distance,
//   elapsed seconds and display mode in tdata and the updated and cleared
//   flags in tuser.
//   A tick without a recompute goes from accept through the OUTPUT state
//   to the result register; a tick that recomputes also passes UPDATE, LOAD,
//   the 44-step restoring divider that forms the average speed, and STORE.
//   One tick is in work at a time: a new tick is taken once the last has
//   loaded its result, even while that finished result still waits.
//   Reset restores the default configuration and clears all statistics.
//   When the receiver stalls, the result holds in the output register and
//   the following tick finishes its work, then waits until the result is taken.
//   The user must write the configuration registers through cfg_we/cfg_addr/
//   cfg_wdata only while no tick is in flight; the block does not enforce this.
`default_nettype none
module bicycle_speed_distance_meter (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [bsdm_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [bsdm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // tdata: mode_button_level[0], wheel_sensor_level[1], zero[7:2]
    input  wire logic [bsdm_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // tdata: speed_centi_kmh[18:0], average_centi_kmh[37:19], distance_mm[77:38],
    //        elapsed_seconds[109:78], display_mode[111:110]
    output logic      [bsdm_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // tuser: stats_updated[0], stats_cleared[1]
    output logic      [bsdm_pkg::M_TUSER_W-1:0]      m_axis_tuser
);

    bsdm_pkg::dp_cmd_t    cmd;
    bsdm_pkg::dp_status_t status;

    bsdm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    bsdm_datapath u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_addr           (cfg_addr),
        .cfg_wdata          (cfg_wdata),
        .mode_button_level  (s_axis_tdata[0]),
        .wheel_sensor_level (s_axis_tdata[1]),
        .cmd                (cmd),
        .status             (status),
        .m_tdata            (m_axis_tdata),
        .m_tuser            (m_axis_tuser)
    );

endmodule
`default_nettype wire

>>> sv/bsdm_div.sv
// Restoring divider for the average speed, one quotient bit per step.
`default_nettype none
module bsdm_div (
    input  wire logic                            clk,
    input  wire logic                            load,
    input  wire logic                            step,
    input  wire logic [bsdm_pkg::DIVD_W-1:0]     avg_dividend,
    input  wire logic [bsdm_pkg::DIVS_W-1:0]     avg_divisor,
    output logic      [bsdm_pkg::DIVD_W-1:0]     avg_quot
);

    logic [bsdm_pkg::DIVD_W-1:0]   aq_reg, aq_next;
    logic [bsdm_pkg::DIVS_W-1:0]   arem_reg, arem_next;
    logic [bsdm_pkg::DIVS_W-1:0]   adiv_reg, adiv_next;
    logic [bsdm_pkg::DIVS_W:0]     arem_sh, arem_diff;
    logic                          age;

    // Shift in the next dividend bit and try the subtract
    always_comb
    begin
        arem_sh   = {arem_reg, aq_reg[bsdm_pkg::DIVD_W-1]};
        arem_diff = arem_sh - {1'b0, adiv_reg};
        age       = (arem_sh >= {1'b0, adiv_reg});

        aq_next   = aq_reg;
        arem_next = arem_reg;
        adiv_next = adiv_reg;
        if (load)
        begin
            aq_next   = avg_dividend;
            arem_next = '0;
            adiv_next = avg_divisor;
        end
        else if (step)
        begin
            aq_next   = {aq_reg[bsdm_pkg::DIVD_W-2:0], age};
            arem_next = age ? arem_diff[bsdm_pkg::DIVS_W-1:0] : arem_sh[bsdm_pkg::DIVS_W-1:0];
        end
    end

    // Hold the working registers
    always_ff @(posedge clk)
    begin
        aq_reg   <= aq_next;
        arem_reg <= arem_next;
        adiv_reg <= adiv_next;
    end

    assign avg_quot = aq_reg;

endmodule
`default_nettype wire

>>> sv/bsdm_datapath.sv
// Datapath: configuration, debounce, period, statistics and result register.
`default_nettype none
`include "bicycle_speed_distance_meter_defines.svh"
module bsdm_datapath (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [bsdm_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [bsdm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire logic                                mode_button_level,
    input  wire logic                                wheel_sensor_level,
    input  wire bsdm_pkg::dp_cmd_t                   cmd,
    output bsdm_pkg::dp_status_t                     status,
    output logic      [bsdm_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic      [bsdm_pkg::M_TUSER_W-1:0]      m_tuser
);

    // Configuration registers
    logic [bsdm_pkg::CIRC_W-1:0] circ_reg;
    logic [bsdm_pkg::DEB_W-1:0]  deb_reg;
    logic [bsdm_pkg::HOLD_W-1:0] hold_reg;
    logic [bsdm_pkg::PER_W-1:0]  period_ms_reg;

    // Tick state
    logic [bsdm_pkg::PERCNT_W-1:0]  period_reg, period_next;
    logic                           btn_last_reg, btn_last_next;
    logic                           btn_steady_reg, btn_steady_next;
    logic [bsdm_pkg::QUIET_W-1:0]   btn_quiet_reg, btn_quiet_next;
    logic [bsdm_pkg::HOLDCNT_W-1:0] btn_hold_reg, btn_hold_next;
    logic                           sen_last_reg, sen_last_next;
    logic                           sen_steady_reg, sen_steady_next;
    logic [bsdm_pkg::QUIET_W-1:0]   sen_quiet_reg, sen_quiet_next;
    logic [bsdm_pkg::TURN_W-1:0]    turn_reg, turn_next;
    logic [bsdm_pkg::MODE_W-1:0]    mode_reg, mode_next;

    // Statistics
    logic [bsdm_pkg::SPEED_W-1:0]   speed_reg, speed_next;
    logic [bsdm_pkg::DIST_W-1:0]    dist_reg, dist_next;
    logic [bsdm_pkg::SECS_W-1:0]    secs_reg, secs_next;
    logic [bsdm_pkg::OUT_W-1:0]     avg_reg, avg_next;
    logic [bsdm_pkg::OUT_W-1:0]     spdc_reg, spdc_next;
    logic                           upd_flag_reg, upd_flag_next;
    logic                           clr_flag_reg, clr_flag_next;

    // Payload registers
    logic [bsdm_pkg::PROD_W-1:0]    prod_reg, prod_next;
    logic [bsdm_pkg::M_TDATA_W-1:0] tdata_reg, tdata_next;
    logic [bsdm_pkg::M_TUSER_W-1:0] tuser_reg, tuser_next;

    // Tick terms
    logic [bsdm_pkg::PERCNT_W-1:0]  period_inc;
    logic                           recompute_now;
    logic [bsdm_pkg::QUIET_W-1:0]   bq_new, sq_new;
    logic [bsdm_pkg::HOLDCNT_W-1:0] bh_new;
    logic                           clear_now, btn_take, sen_take;
    logic [bsdm_pkg::TURN_W-1:0]    turn_base;

    // Update and divider operands
    logic [bsdm_pkg::SUM_W-1:0]      speed_sum;
    logic [bsdm_pkg::SPEED_W-1:0]    speed_new;
    logic [bsdm_pkg::DIST_W:0]       dist_sum;
    logic [bsdm_pkg::DIVD_W-1:0]     avg_dividend, avg_quot;
    logic [bsdm_pkg::DIVS_W-1:0]     avg_divisor;
    logic [bsdm_pkg::SPD_PROD_W-1:0] spd_prod;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            circ_reg      <= bsdm_pkg::CIRC_RST;
            deb_reg       <= bsdm_pkg::DEB_RST;
            hold_reg      <= bsdm_pkg::HOLD_RST;
            period_ms_reg <= bsdm_pkg::PERIOD_RST;
        end
        else if (cfg_we)
        begin
            case (bsdm_pkg::cfg_index_t'(cfg_addr))
                bsdm_pkg::CFG_CIRC:     circ_reg      <= cfg_wdata[bsdm_pkg::CIRC_W-1:0];
                bsdm_pkg::CFG_DEBOUNCE: deb_reg       <= cfg_wdata[bsdm_pkg::DEB_W-1:0];
                bsdm_pkg::CFG_HOLD:     hold_reg      <= cfg_wdata;
                bsdm_pkg::CFG_PERIOD:   period_ms_reg <= cfg_wdata;
                default:                circ_reg      <= circ_reg;
            endcase
        end
    end

    // Evaluate period, button and sensor for the incoming tick
    always_comb
    begin
        period_inc    = (&period_reg) ? period_reg : period_reg + 1'b1;
        recompute_now = period_inc > {1'b0, period_ms_reg};

        if (mode_button_level != btn_last_reg)
        begin
            bq_new = '0;
            bh_new = '0;
        end
        else
        begin
            bq_new = (&btn_quiet_reg) ? btn_quiet_reg : btn_quiet_reg + 1'b1;
            bh_new = (&btn_hold_reg) ? btn_hold_reg : btn_hold_reg + 1'b1;
        end
        clear_now = !btn_steady_reg && !mode_button_level && (bh_new > {1'b0, hold_reg});
        btn_take  = bq_new > {1'b0, deb_reg};

        if (wheel_sensor_level != sen_last_reg)
            sq_new = '0;
        else
            sq_new = (&sen_quiet_reg) ? sen_quiet_reg : sen_quiet_reg + 1'b1;
        sen_take  = sq_new > {1'b0, deb_reg};

        turn_base = recompute_now ? '0 : turn_reg;
    end

    assign status.recompute = recompute_now && !clear_now;
    assign status.clear     = clear_now;

    // Smoothed speed and saturating distance for the update step
    always_comb
    begin
        speed_sum = bsdm_pkg::SUM_W'(prod_reg) + bsdm_pkg::SUM_W'(speed_reg);
        speed_new = speed_sum[bsdm_pkg::SUM_W-1:1];
        dist_sum  = (bsdm_pkg::DIST_W+1)'(dist_reg) + (bsdm_pkg::DIST_W+1)'(speed_new);
    end

    // Divider operands: distance times 9, seconds times 25; speed by reciprocal
    always_comb
    begin
        avg_dividend = (bsdm_pkg::DIVD_W'(dist_reg) << 3) + bsdm_pkg::DIVD_W'(dist_reg);
        avg_divisor  = (bsdm_pkg::DIVS_W'(secs_reg) << 4) + (bsdm_pkg::DIVS_W'(secs_reg) << 3)
                     + bsdm_pkg::DIVS_W'(secs_reg);
        spd_prod     = bsdm_pkg::SPD_PROD_W'(speed_reg) * bsdm_pkg::SPD_PROD_W'(bsdm_pkg::SPD_RECIP);
    end

    bsdm_div u_div (
        .clk          (clk),
        .load         (cmd.div_load),
        .step         (cmd.div_step),
        .avg_dividend (avg_dividend),
        .avg_divisor  (avg_divisor),
        .avg_quot     (avg_quot)
    );

    // Next state per command
    always_comb
    begin
        period_next     = period_reg;
        btn_last_next   = btn_last_reg;
        btn_steady_next = btn_steady_reg;
        btn_quiet_next  = btn_quiet_reg;
        btn_hold_next   = btn_hold_reg;
        sen_last_next   = sen_last_reg;
        sen_steady_next = sen_steady_reg;
        sen_quiet_next  = sen_quiet_reg;
        turn_next       = turn_reg;
        mode_next       = mode_reg;
        speed_next      = speed_reg;
        dist_next       = dist_reg;
        secs_next       = secs_reg;
        avg_next        = avg_reg;
        spdc_next       = spdc_reg;
        upd_flag_next   = upd_flag_reg;
        clr_flag_next   = clr_flag_reg;
        prod_next       = prod_reg;
        tdata_next      = tdata_reg;
        tuser_next      = tuser_reg;

        if (cmd.tick)
        begin
            // Advance counters, debounce and turn count
            period_next    = recompute_now ? '0 : period_inc;
            btn_last_next  = mode_button_level;
            btn_quiet_next = bq_new;
            btn_hold_next  = clear_now ? '0 : bh_new;
            if (btn_take)
                btn_steady_next = mode_button_level;
            sen_last_next  = wheel_sensor_level;
            sen_quiet_next = sq_new;
            if (sen_take)
                sen_steady_next = wheel_sensor_level;
            if (sen_take && sen_steady_reg && !wheel_sensor_level)
                turn_next = (&turn_base) ? turn_base : turn_base + 1'b1;
            else
                turn_next = turn_base;

            if (clear_now)
                mode_next = '0;
            else if (btn_take && btn_steady_reg && !mode_button_level)
                mode_next = mode_reg + 1'b1;

            // Drop statistics on a long hold
            if (clear_now)
            begin
                speed_next = '0;
                dist_next  = '0;
                secs_next  = '0;
                avg_next   = '0;
                spdc_next  = '0;
            end

            prod_next     = bsdm_pkg::PROD_W'(turn_reg) * bsdm_pkg::PROD_W'(circ_reg);
            upd_flag_next = recompute_now;
            clr_flag_next = clear_now;
        end

        if (cmd.update)
        begin
            speed_next = speed_new;
            dist_next  = dist_sum[bsdm_pkg::DIST_W] ? '1 : dist_sum[bsdm_pkg::DIST_W-1:0];
            secs_next  = (&secs_reg) ? secs_reg : secs_reg + 1'b1;
        end

        if (cmd.store)
        begin
            avg_next  = bsdm_pkg::sat_out(avg_quot);
            spdc_next = bsdm_pkg::sat_out(bsdm_pkg::DIVD_W'(
                            spd_prod[bsdm_pkg::SPD_PROD_W-1:bsdm_pkg::SPD_SHIFT]));
        end

        if (cmd.out_load)
        begin
            tdata_next = {mode_reg, secs_reg, dist_reg, avg_reg, spdc_reg};
            tuser_next = {clr_flag_reg, upd_flag_reg};
        end
    end

    // Hold control and statistics state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg     <= '0;
            btn_last_reg   <= 1'b0;
            btn_steady_reg <= 1'b0;
            btn_quiet_reg  <= '1;
            btn_hold_reg   <= '1;
            sen_last_reg   <= 1'b0;
            sen_steady_reg <= 1'b0;
            sen_quiet_reg  <= '1;
            turn_reg       <= '0;
            mode_reg       <= '0;
            speed_reg      <= '0;
            dist_reg       <= '0;
            secs_reg       <= '0;
            avg_reg        <= '0;
            spdc_reg       <= '0;
            upd_flag_reg   <= 1'b0;
            clr_flag_reg   <= 1'b0;
        end
        else
        begin
            period_reg     <= period_next;
            btn_last_reg   <= btn_last_next;
            btn_steady_reg <= btn_steady_next;
            btn_quiet_reg  <= btn_quiet_next;
            btn_hold_reg   <= btn_hold_next;
            sen_last_reg   <= sen_last_next;
            sen_steady_reg <= sen_steady_next;
            sen_quiet_reg  <= sen_quiet_next;
            turn_reg       <= turn_next;
            mode_reg       <= mode_next;
            speed_reg      <= speed_next;
            dist_reg       <= dist_next;
            secs_reg       <= secs_next;
            avg_reg        <= avg_next;
            spdc_reg       <= spdc_next;
            upd_flag_reg   <= upd_flag_next;
            clr_flag_reg   <= clr_flag_next;
        end
    end

    // Hold payload registers
    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        tdata_reg <= tdata_next;
        tuser_reg <= tuser_next;
    end

    assign m_tdata = tdata_reg;
    assign m_tuser = tuser_reg;

    `BSDM_ASSERT_NEXT(a_clear_zeroes_stats, clk, rst_n, cmd.tick && clear_now, (dist_reg == '0) && (secs_reg == '0) && (mode_reg == '0), "long hold left statistics set")

endmodule
`default_nettype wire

>>> sv/bsdm_ctrl.sv
// Controller: sequences tick, update, divide, store and result hand-off.
`default_nettype none
`include "bicycle_speed_distance_meter_defines.svh"
module bsdm_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    input  wire bsdm_pkg::dp_status_t status,
    output bsdm_pkg::dp_cmd_t         cmd
);

    bsdm_pkg::state_t              state_reg, state_next;
    logic [bsdm_pkg::STEP_W-1:0]   step_reg, step_next;
    logic                          out_valid_reg, out_valid_next;

    // Hold state, step count and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bsdm_pkg::ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        in_ready   = 1'b0;

        case (state_reg)
            bsdm_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.tick   = 1'b1;
                    state_next = status.recompute ? bsdm_pkg::ST_UPDATE : bsdm_pkg::ST_OUTPUT;
                end
            end
            bsdm_pkg::ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = bsdm_pkg::ST_LOAD;
            end
            bsdm_pkg::ST_LOAD:
            begin
                cmd.div_load = 1'b1;
                step_next    = '0;
                state_next   = bsdm_pkg::ST_DIVIDE;
            end
            bsdm_pkg::ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == bsdm_pkg::STEP_W'(bsdm_pkg::DIV_STEPS - 1))
                    state_next = bsdm_pkg::ST_STORE;
            end
            bsdm_pkg::ST_STORE:
            begin
                cmd.store  = 1'b1;
                state_next = bsdm_pkg::ST_OUTPUT;
            end
            bsdm_pkg::ST_OUTPUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = bsdm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bsdm_pkg::ST_IDLE;
            end
        endcase
    end

    // Raise valid on a new result, drop it once taken
    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

    `BSDM_ASSERT_NOW(a_cmd_exclusive, clk, rst_n, 1'b1, $onehot0(cmd), "more than one datapath command")
    `BSDM_ASSERT_NOW(a_no_overwrite, clk, rst_n, cmd.out_load, !out_valid_reg || out_ready, "result overwritten before taken")
    `BSDM_ASSERT_NOW(a_step_bound, clk, rst_n, state_reg == bsdm_pkg::ST_DIVIDE, step_reg < bsdm_pkg::STEP_W'(bsdm_pkg::DIV_STEPS), "divide ran past its step count")
    `BSDM_ASSERT_NEXT(a_load_starts_divide, clk, rst_n, cmd.div_load, (state_reg == bsdm_pkg::ST_DIVIDE) && (step_reg == '0), "divide did not start after load")

endmodule
`default_nettype wire
